FILE: src/nud_pkg.sv
// ----------------------------------------------------------------------------
// nud_pkg
// Shared types and constants for the NAL unit deframer: queue entry layout,
// result kind and status codes, byte values used by the escape logic.
// ----------------------------------------------------------------------------
package nud_pkg;

   // Width of the length fields on the result port
   localparam int RSP_LEN_W = 16;

   // Depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Byte values
   localparam logic [7:0] BYTE_ZERO   = 8'h00;
   localparam logic [7:0] BYTE_ESCAPE = 8'h03;

   // Result kind
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // Summary status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_VIOLATION = 2'd1;
   localparam logic [1:0] STATUS_NO_STOP   = 2'd2;

   // Zero run value that arms the escape check
   localparam logic [1:0] ZERO_RUN_FULL = 2'd2;

   // One classified beat handed from front to back
   typedef struct packed {
      logic                 has_payload;
      logic [7:0]           payload_byte;
      logic                 has_summary;
      logic [7:0]           header;
      logic [RSP_LEN_W-1:0] rbsp_length;
      logic [RSP_LEN_W-1:0] sodb_length;
      logic [1:0]           status;
   } entry_type;

endpackage

FILE: src/nud_front.sv
// ----------------------------------------------------------------------------
// nud_front
// Accepts input beats, tracks start code, header and escape state, and pushes
// one queue entry per beat that yields a payload byte and/or a unit summary.
// ----------------------------------------------------------------------------
module nud_front #(
   parameter int LENGTH_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_data_byte,
   input  logic                req_first_of_unit,
   input  logic                req_last_of_unit,
   input  logic [2:0]          req_start_code_len,
   output logic                push_valid,
   input  logic                push_ready,
   output nud_pkg::entry_type  push_entry
);

   localparam logic [LENGTH_BITS-1:0] LenMax = {LENGTH_BITS{1'b1}};

   logic [2:0]             prefix_ff, prefix_in, cur_prefix;
   logic                   hdr_pend_ff, hdr_pend_in, cur_hdr_pend;
   logic [1:0]             zero_run_ff, zero_run_in, cur_zero_run;
   logic                   after_esc_ff, after_esc_in, cur_after_esc;
   logic [LENGTH_BITS-1:0] byte_cnt_ff, byte_cnt_in, cur_byte_cnt, byte_cnt_inc;
   logic [LENGTH_BITS-1:0] nz_end_ff, nz_end_in, cur_nz_end;
   logic [7:0]             header_ff, header_in, cur_header;
   logic                   error_ff, error_in, cur_error;
   logic                   emit;
   logic                   removed;
   logic                   accept;
   logic [nud_pkg::RSP_LEN_W-1:0] rbsp_sat;
   logic [nud_pkg::RSP_LEN_W-1:0] sodb_sat;
   logic [1:0]             status;

   // First byte of a unit restarts the unit state
   always_comb begin
      if (req_first_of_unit) begin
         cur_prefix    = req_start_code_len;
         cur_hdr_pend  = 1'b1;
         cur_zero_run  = 2'd0;
         cur_after_esc = 1'b0;
         cur_byte_cnt  = '0;
         cur_nz_end    = '0;
         cur_header    = 8'h00;
         cur_error     = 1'b0;
      end else begin
         cur_prefix    = prefix_ff;
         cur_hdr_pend  = hdr_pend_ff;
         cur_zero_run  = zero_run_ff;
         cur_after_esc = after_esc_ff;
         cur_byte_cnt  = byte_cnt_ff;
         cur_nz_end    = nz_end_ff;
         cur_header    = header_ff;
         cur_error     = error_ff;
      end
   end

   assign byte_cnt_inc = (cur_byte_cnt != LenMax) ? cur_byte_cnt + 1'b1 : cur_byte_cnt;

   // Classify the byte: start code, header, escape, payload
   always_comb begin
      prefix_in    = cur_prefix;
      hdr_pend_in  = cur_hdr_pend;
      zero_run_in  = cur_zero_run;
      after_esc_in = cur_after_esc;
      byte_cnt_in  = cur_byte_cnt;
      nz_end_in    = cur_nz_end;
      header_in    = cur_header;
      error_in     = cur_error;
      emit         = 1'b0;
      removed      = 1'b0;
      if (cur_prefix != 3'd0) begin
         prefix_in = cur_prefix - 3'd1;
      end else if (cur_hdr_pend) begin
         header_in   = req_data_byte;
         hdr_pend_in = 1'b0;
      end else if (!cur_error) begin
         if (cur_after_esc) begin
            after_esc_in = 1'b0;
            if (req_data_byte > nud_pkg::BYTE_ESCAPE) begin
               error_in = 1'b1;
            end
         end else if (cur_zero_run == nud_pkg::ZERO_RUN_FULL) begin
            if (req_data_byte < nud_pkg::BYTE_ESCAPE) begin
               error_in = 1'b1;
            end else if (req_data_byte == nud_pkg::BYTE_ESCAPE) begin
               after_esc_in = 1'b1;
               zero_run_in  = 2'd0;
               removed      = 1'b1;
            end
         end
         if (!error_in && !removed) begin
            emit        = 1'b1;
            byte_cnt_in = byte_cnt_inc;
            if (req_data_byte == nud_pkg::BYTE_ZERO) begin
               if (cur_zero_run != nud_pkg::ZERO_RUN_FULL) begin
                  zero_run_in = cur_zero_run + 2'd1;
               end
            end else begin
               zero_run_in = 2'd0;
               nz_end_in   = byte_cnt_inc;
            end
         end
      end
   end

   // Saturate lengths to the result field width, or zero-extend them when they fit
   generate
      if (LENGTH_BITS > nud_pkg::RSP_LEN_W) begin : g_sat
         assign rbsp_sat = (byte_cnt_in[LENGTH_BITS-1:nud_pkg::RSP_LEN_W] != '0) ?
                           {nud_pkg::RSP_LEN_W{1'b1}} :
                           byte_cnt_in[nud_pkg::RSP_LEN_W-1:0];
         assign sodb_sat = (nz_end_in[LENGTH_BITS-1:nud_pkg::RSP_LEN_W] != '0) ?
                           {nud_pkg::RSP_LEN_W{1'b1}} :
                           nz_end_in[nud_pkg::RSP_LEN_W-1:0];
      end else begin : g_ext
         assign rbsp_sat = nud_pkg::RSP_LEN_W'(byte_cnt_in);
         assign sodb_sat = nud_pkg::RSP_LEN_W'(nz_end_in);
      end
   endgenerate

   // Summary status
   always_comb begin
      if (error_in) begin
         status = nud_pkg::STATUS_VIOLATION;
      end else if (nz_end_in == '0) begin
         status = nud_pkg::STATUS_NO_STOP;
      end else begin
         status = nud_pkg::STATUS_OK;
      end
   end

   // Queue push
   assign req_ready  = push_ready;
   assign accept     = req_valid && push_ready;
   assign push_valid = req_valid && (emit || req_last_of_unit);

   always_comb begin
      push_entry              = '0;
      push_entry.has_payload  = emit;
      push_entry.payload_byte = req_data_byte;
      push_entry.has_summary  = req_last_of_unit;
      push_entry.header       = header_in;
      push_entry.rbsp_length  = rbsp_sat;
      push_entry.sodb_length  = sodb_sat;
      push_entry.status       = status;
   end

   // Unit state
   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff    <= 3'd0;
         hdr_pend_ff  <= 1'b0;
         zero_run_ff  <= 2'd0;
         after_esc_ff <= 1'b0;
         byte_cnt_ff  <= '0;
         nz_end_ff    <= '0;
         header_ff    <= 8'h00;
         error_ff     <= 1'b0;
      end else if (accept) begin
         prefix_ff    <= prefix_in;
         hdr_pend_ff  <= hdr_pend_in;
         zero_run_ff  <= zero_run_in;
         after_esc_ff <= after_esc_in;
         byte_cnt_ff  <= byte_cnt_in;
         nz_end_ff    <= nz_end_in;
         header_ff    <= header_in;
         error_ff     <= error_in;
      end
   end

   // Stop-bit position never runs past the byte count
   a_nz_within_count: assert property (@(posedge clock) disable iff (reset)
      nz_end_ff <= byte_cnt_ff)
      else $error("last nonzero end beyond byte count");

endmodule

FILE: src/nud_queue.sv
// ----------------------------------------------------------------------------
// nud_queue
// Short FIFO of classified entries between the front and the back.
// ----------------------------------------------------------------------------
module nud_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  nud_pkg::entry_type push_entry,
   output logic               pop_valid,
   input  logic               pop,
   output nud_pkg::entry_type pop_entry
);

   localparam logic [nud_pkg::QUEUE_CNT_W-1:0] CntFull =
      nud_pkg::QUEUE_CNT_W'(nud_pkg::QUEUE_DEPTH);
   localparam logic [nud_pkg::QUEUE_PTR_W-1:0] PtrLast =
      nud_pkg::QUEUE_PTR_W'(nud_pkg::QUEUE_DEPTH - 1);

   nud_pkg::entry_type                entries_ff [nud_pkg::QUEUE_DEPTH];
   logic [nud_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [nud_pkg::QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [nud_pkg::QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                              do_push;
   logic                              do_pop;

   assign push_ready = (count_ff != CntFull);
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntFull)
      else $error("queue fill count past depth");

   a_ptr_consistent: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == CntFull) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with fill count");

endmodule

FILE: src/nud_back.sv
// ----------------------------------------------------------------------------
// nud_back
// Pops queue entries and drives the result register; an entry that holds
// both a payload byte and a summary goes out as two beats.
// ----------------------------------------------------------------------------
module nud_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            head_valid,
   input  nud_pkg::entry_type              head_entry,
   output logic                            head_pop,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_kind,
   output logic [7:0]                      rsp_payload_byte,
   output logic                            rsp_end_of_unit,
   output logic                            rsp_f_zero_bit,
   output logic [1:0]                      rsp_ref_idc,
   output logic [4:0]                      rsp_unit_type,
   output logic [nud_pkg::RSP_LEN_W-1:0]   rsp_rbsp_length,
   output logic [nud_pkg::RSP_LEN_W-1:0]   rsp_sodb_length,
   output logic [1:0]                      rsp_status
);

   logic                          valid_ff, valid_in;
   logic                          phase_ff, phase_in;
   logic                          kind_ff, kind_in;
   logic [7:0]                    byte_ff, byte_in;
   logic [7:0]                    header_ff, header_in;
   logic [nud_pkg::RSP_LEN_W-1:0] rbsp_ff, rbsp_in;
   logic [nud_pkg::RSP_LEN_W-1:0] sodb_ff, sodb_in;
   logic [1:0]                    status_ff, status_in;
   logic                          load;
   logic                          sel_summary;

   assign load        = head_valid && (!valid_ff || rsp_ready);
   assign sel_summary = !head_entry.has_payload || phase_ff;
   assign head_pop    = load && (sel_summary || !head_entry.has_summary);

   // Next result beat
   always_comb begin
      valid_in  = valid_ff && !rsp_ready;
      phase_in  = phase_ff;
      kind_in   = kind_ff;
      byte_in   = byte_ff;
      header_in = header_ff;
      rbsp_in   = rbsp_ff;
      sodb_in   = sodb_ff;
      status_in = status_ff;
      if (load) begin
         valid_in = 1'b1;
         phase_in = !sel_summary && head_entry.has_summary;
         if (sel_summary) begin
            kind_in   = nud_pkg::KIND_SUMMARY;
            byte_in   = 8'h00;
            header_in = head_entry.header;
            rbsp_in   = head_entry.rbsp_length;
            sodb_in   = head_entry.sodb_length;
            status_in = head_entry.status;
         end else begin
            kind_in   = nud_pkg::KIND_PAYLOAD;
            byte_in   = head_entry.payload_byte;
            header_in = 8'h00;
            rbsp_in   = '0;
            sodb_in   = '0;
            status_in = nud_pkg::STATUS_OK;
         end
      end
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      byte_ff   <= byte_in;
      header_ff <= header_in;
      rbsp_ff   <= rbsp_in;
      sodb_ff   <= sodb_in;
      status_ff <= status_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_payload_byte  = byte_ff;
   assign rsp_end_of_unit   = (kind_ff == nud_pkg::KIND_SUMMARY);
   assign rsp_f_zero_bit    = header_ff[7];
   assign rsp_ref_idc       = header_ff[6:5];
   assign rsp_unit_type     = header_ff[4:0];
   assign rsp_rbsp_length   = rbsp_ff;
   assign rsp_sodb_length   = sodb_ff;
   assign rsp_status        = status_ff;

   // Split entry stays at the queue head until its summary beat goes out
   a_phase_holds_head: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (head_valid && head_entry.has_payload && head_entry.has_summary))
      else $error("summary half pending without its queue entry");

   a_phase_after_payload: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (valid_ff && kind_ff == nud_pkg::KIND_PAYLOAD))
      else $error("summary half pending but no payload beat shown");

endmodule

FILE: src/nal_unit_deframer_unit.sv
// ----------------------------------------------------------------------------
// nal_unit_deframer_unit
// H.264 NAL unit deframer: drops start code, splits the header, removes
// emulation-prevention bytes and reports a per-unit summary.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake             | Beat
//  --------+-----------+-----------------------+-------------------------------
//  req_    | in        | req_valid / req_ready | one byte of the unit + marks
//  rsp_    | out       | rsp_valid / rsp_ready | RBSP byte or unit summary
//
//  One input byte per clock while req_ready is high; an accepted input's entry
//  goes into the queue at the accepting edge, then into the result register.
//  The final byte of a unit that also yields a payload byte takes two output
//  beats, set by the single result register of the back end.
//  A four-entry queue parts front and back; req_ready drops only when it fills.
//  Synchronous active-high reset clears unit state, queue and result valid.
// ----------------------------------------------------------------------------
module nal_unit_deframer_unit #(
   parameter int LENGTH_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_data_byte,
   input  logic                            req_first_of_unit,
   input  logic                            req_last_of_unit,
   input  logic [2:0]                      req_start_code_len,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_kind,
   output logic [7:0]                      rsp_payload_byte,
   output logic                            rsp_end_of_unit,
   output logic                            rsp_f_zero_bit,
   output logic [1:0]                      rsp_ref_idc,
   output logic [4:0]                      rsp_unit_type,
   output logic [nud_pkg::RSP_LEN_W-1:0]   rsp_rbsp_length,
   output logic [nud_pkg::RSP_LEN_W-1:0]   rsp_sodb_length,
   output logic [1:0]                      rsp_status
);

   logic               push_valid;
   logic               push_ready;
   nud_pkg::entry_type push_entry;
   logic               head_valid;
   logic               head_pop;
   nud_pkg::entry_type head_entry;

   // Front: classification and unit state
   nud_front #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_first_of_unit  (req_first_of_unit),
      .req_last_of_unit   (req_last_of_unit),
      .req_start_code_len (req_start_code_len),
      .push_valid         (push_valid),
      .push_ready         (push_ready),
      .push_entry         (push_entry)
   );

   // Queue between front and back
   nud_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (head_valid),
      .pop        (head_pop),
      .pop_entry  (head_entry)
   );

   // Back: result beats
   nud_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_entry        (head_entry),
      .head_pop          (head_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_end_of_unit   (rsp_end_of_unit),
      .rsp_f_zero_bit    (rsp_f_zero_bit),
      .rsp_ref_idc       (rsp_ref_idc),
      .rsp_unit_type     (rsp_unit_type),
      .rsp_rbsp_length   (rsp_rbsp_length),
      .rsp_sodb_length   (rsp_sodb_length),
      .rsp_status        (rsp_status)
   );

endmodule
